[rtl/core/gwns_pkg.sv]
// Shared types and constants for the grid window neighbour scan core.
`default_nettype none

package gwns_pkg;

	// Grid geometry and field widths.
	localparam int GRID_SIDE_MAX    = 64;
	localparam int MAX_VICINITY     = 3;
	localparam int OCCUPANT_ID_BITS = 16;
	localparam int COORD_W          = $clog2(GRID_SIDE_MAX);
	localparam int CELL_AW          = 2 * COORD_W;
	localparam int EXT_W            = 7;
	localparam int VIC_W            = 2;
	localparam int CNT_W            = 6;
	localparam int MAX_HITS         = (2 * MAX_VICINITY + 1) * (2 * MAX_VICINITY + 1);
	localparam int MEM_W            = OCCUPANT_ID_BITS + 1;

	// Configuration port.
	localparam int PADDR_W          = 3;
	localparam int PDATA_W          = 32;
	localparam logic REG_GRID_EXTENT = 1'b0;
	localparam logic [EXT_W-1:0] EXTENT_RESET = EXT_W'(GRID_SIDE_MAX);

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_WRITE     = 2'd0,
		REQ_COUNT     = 2'd1,
		REQ_LIST_OCC  = 2'd2,
		REQ_LIST_FREE = 2'd3
	} req_kind_t;

	// Input word.
	typedef struct packed {
		req_kind_t                     req_type;
		logic [COORD_W-1:0]            pos_x;
		logic [COORD_W-1:0]            pos_y;
		logic [VIC_W-1:0]              vicinity;
		logic                          include_center;
		logic                          cell_occupied;
		logic [OCCUPANT_ID_BITS-1:0]   occupant_in;
	} req_word_t;

	// Result word.
	typedef struct packed {
		logic                          entry_valid;
		logic                          out_of_range;
		logic [COORD_W-1:0]            cell_x;
		logic [COORD_W-1:0]            cell_y;
		logic [OCCUPANT_ID_BITS-1:0]   occupant_out;
		logic [CNT_W-1:0]              hit_count;
		logic                          last;
	} rsp_word_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR  = 3'd0,
		ST_IDLE   = 3'd1,
		ST_START  = 3'd2,
		ST_SCAN   = 3'd3,
		ST_FINISH = 3'd4
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic clear_en;
		logic ready;
		logic start;
		logic scan;
		logic finish;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic clear_last;
		logic oor;
		logic is_write;
		logic scan_empty;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/gwns_ctrl.sv]
// Controller state machine for the grid window neighbour scan core.
`default_nettype none

module gwns_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire gwns_pkg::sts_t sts,
	output gwns_pkg::cmd_t     cmd
);

	gwns_pkg::state_t state_q;
	gwns_pkg::state_t state_next;

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwns_pkg::ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			gwns_pkg::ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_next = gwns_pkg::ST_IDLE;
				end
			end
			gwns_pkg::ST_IDLE: begin
				cmd.ready = 1'b1;
				if (req_valid) begin
					state_next = gwns_pkg::ST_START;
				end
			end
			gwns_pkg::ST_START: begin
				cmd.start = 1'b1;
				if (sts.oor || sts.is_write) begin
					state_next = gwns_pkg::ST_FINISH;
				end else begin
					state_next = gwns_pkg::ST_SCAN;
				end
			end
			gwns_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_empty) begin
					state_next = gwns_pkg::ST_FINISH;
				end
			end
			gwns_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				if (sts.out_free) begin
					state_next = gwns_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = gwns_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/gwns_datapath.sv]
// Datapath of the grid window neighbour scan core: grid memory, scan counters and result register.
`default_nettype none

module gwns_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [gwns_pkg::EXT_W-1:0]      grid_extent,
	input  wire logic                            req_valid,
	input  wire gwns_pkg::req_word_t             req_word,
	input  wire gwns_pkg::cmd_t                  cmd,
	output gwns_pkg::sts_t                       sts,
	output logic                                 rsp_valid,
	output gwns_pkg::rsp_word_t                  rsp_word,
	input  wire logic                            rsp_stall
);

	// Grid memory: occupied bit on top of the occupant id.
	logic [gwns_pkg::MEM_W-1:0] mem [0:(1 << gwns_pkg::CELL_AW)-1];

	gwns_pkg::req_word_t                req_q;
	logic [gwns_pkg::CELL_AW-1:0]       clr_addr_q;
	logic                               oor_q;
	logic [gwns_pkg::COORD_W-1:0]       maxx_q, miny_q, maxy_q;
	logic [gwns_pkg::COORD_W-1:0]       x_q, y_q;
	logic                               issue_done_q;
	logic                               valid_s1;
	logic [gwns_pkg::COORD_W-1:0]       x_s1, y_s1;
	logic [gwns_pkg::MEM_W-1:0]         mem_rd_s1;
	logic [gwns_pkg::CNT_W-1:0]         hits_q;
	logic                               pend_valid_q;
	gwns_pkg::rsp_word_t                pend_q;
	logic                               rsp_valid_q;
	gwns_pkg::rsp_word_t                rsp_q;

	logic [gwns_pkg::EXT_W-1:0]         ext_eff, ext_m1;
	logic [gwns_pkg::VIC_W-1:0]         vic_eff;
	logic [gwns_pkg::EXT_W-1:0]         sumx, sumy;
	logic [gwns_pkg::COORD_W-1:0]       minx_c, maxx_c, miny_c, maxy_c;
	logic                               oor_c, is_write_c;
	logic                               take;
	logic                               mem_we;
	logic [gwns_pkg::CELL_AW-1:0]       mem_wa;
	logic [gwns_pkg::MEM_W-1:0]         mem_wd;
	logic                               centre_s1, occ_s1, counted_s1, list_hit_s1;
	logic                               out_free, hold, consume, issue, out_load;
	gwns_pkg::rsp_word_t                entry_s1, out_next;

	assign take = cmd.ready && req_valid;

	// Effective extent and radius, window bounds clipped to the grid.
	always_comb begin
		if (grid_extent == '0) begin
			ext_eff = gwns_pkg::EXT_W'(1);
		end else if (grid_extent > gwns_pkg::EXT_W'(gwns_pkg::GRID_SIDE_MAX)) begin
			ext_eff = gwns_pkg::EXT_W'(gwns_pkg::GRID_SIDE_MAX);
		end else begin
			ext_eff = grid_extent;
		end
		ext_m1  = ext_eff - gwns_pkg::EXT_W'(1);
		vic_eff = (req_q.vicinity > gwns_pkg::VIC_W'(gwns_pkg::MAX_VICINITY)) ?
			gwns_pkg::VIC_W'(gwns_pkg::MAX_VICINITY) : req_q.vicinity;
		oor_c = ({1'b0, req_q.pos_x} >= ext_eff) || ({1'b0, req_q.pos_y} >= ext_eff);
		is_write_c = (req_q.req_type == gwns_pkg::REQ_WRITE);
		minx_c = (req_q.pos_x > gwns_pkg::COORD_W'(vic_eff)) ?
			req_q.pos_x - gwns_pkg::COORD_W'(vic_eff) : '0;
		miny_c = (req_q.pos_y > gwns_pkg::COORD_W'(vic_eff)) ?
			req_q.pos_y - gwns_pkg::COORD_W'(vic_eff) : '0;
		sumx = {1'b0, req_q.pos_x} + gwns_pkg::EXT_W'(vic_eff);
		sumy = {1'b0, req_q.pos_y} + gwns_pkg::EXT_W'(vic_eff);
		maxx_c = (sumx > ext_m1) ? ext_m1[gwns_pkg::COORD_W-1:0] : sumx[gwns_pkg::COORD_W-1:0];
		maxy_c = (sumy > ext_m1) ? ext_m1[gwns_pkg::COORD_W-1:0] : sumy[gwns_pkg::COORD_W-1:0];
	end

	// Evaluation of the cell whose read data is in stage one.
	always_comb begin
		centre_s1  = (x_s1 == req_q.pos_x) && (y_s1 == req_q.pos_y);
		occ_s1     = mem_rd_s1[gwns_pkg::MEM_W-1];
		counted_s1 = (req_q.req_type != gwns_pkg::REQ_LIST_FREE) &&
			(!centre_s1 || req_q.include_center) && occ_s1;
		case (req_q.req_type)
			gwns_pkg::REQ_LIST_FREE: list_hit_s1 = !centre_s1 && !occ_s1;
			gwns_pkg::REQ_LIST_OCC:  list_hit_s1 = counted_s1;
			default:                 list_hit_s1 = 1'b0;
		endcase
		entry_s1             = '0;
		entry_s1.entry_valid = 1'b1;
		entry_s1.cell_x      = x_s1;
		entry_s1.cell_y      = y_s1;
		if (req_q.req_type == gwns_pkg::REQ_LIST_OCC) begin
			entry_s1.occupant_out = mem_rd_s1[gwns_pkg::OCCUPANT_ID_BITS-1:0];
		end
	end

	// Scan flow control: a found entry pushes the pending one out.
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign hold     = valid_s1 && list_hit_s1 && pend_valid_q && !out_free;
	assign consume  = cmd.scan && valid_s1 && !hold;
	assign issue    = cmd.scan && !hold && !issue_done_q;

	// Result selection.
	always_comb begin
		out_load = 1'b0;
		out_next = pend_q;
		if (consume && list_hit_s1 && pend_valid_q) begin
			out_load      = 1'b1;
			out_next.last = 1'b0;
		end else if (cmd.finish && out_free) begin
			out_load      = 1'b1;
			out_next      = '0;
			out_next.last = 1'b1;
			if (oor_q) begin
				out_next.out_of_range = 1'b1;
			end else if (req_q.req_type == gwns_pkg::REQ_COUNT) begin
				out_next.hit_count = hits_q;
			end else if (pend_valid_q) begin
				out_next      = pend_q;
				out_next.last = 1'b1;
			end
		end
	end

	// Memory write port: clearing pass or cell write.
	always_comb begin
		mem_we = cmd.clear_en || (cmd.start && is_write_c && !oor_c);
		if (cmd.clear_en) begin
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else begin
			mem_wa = {req_q.pos_y, req_q.pos_x};
			mem_wd = {req_q.cell_occupied, req_q.occupant_in[gwns_pkg::OCCUPANT_ID_BITS-1:0]};
		end
	end

	// Grid memory, one write or one registered read a cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			mem_rd_s1 <= mem[{y_q, x_q}];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			oor_q        <= 1'b0;
			issue_done_q <= 1'b1;
			valid_s1     <= 1'b0;
			hits_q       <= '0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + gwns_pkg::CELL_AW'(1);
			end
			if (cmd.start) begin
				oor_q        <= oor_c;
				issue_done_q <= 1'b0;
				valid_s1     <= 1'b0;
				hits_q       <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.scan) begin
				if (!hold) begin
					valid_s1 <= issue;
				end
				if (issue && (x_q == maxx_q) && (y_q == maxy_q)) begin
					issue_done_q <= 1'b1;
				end
				if (consume && counted_s1) begin
					hits_q <= hits_q + gwns_pkg::CNT_W'(1);
				end
				if (consume && list_hit_s1) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= req_word;
		end
		if (cmd.start) begin
			maxx_q <= maxx_c;
			miny_q <= miny_c;
			maxy_q <= maxy_c;
			x_q    <= minx_c;
			y_q    <= miny_c;
		end else if (issue) begin
			x_s1 <= x_q;
			y_s1 <= y_q;
			// y runs inner, x outer.
			if (y_q == maxy_q) begin
				y_q <= miny_q;
				x_q <= x_q + gwns_pkg::COORD_W'(1);
			end else begin
				y_q <= y_q + gwns_pkg::COORD_W'(1);
			end
		end
		if (consume && list_hit_s1) begin
			pend_q <= entry_s1;
		end
		if (out_load) begin
			rsp_q <= out_next;
		end
	end

	assign sts.clear_last = (clr_addr_q == '1);
	assign sts.oor        = oor_c;
	assign sts.is_write   = is_write_c;
	assign sts.scan_empty = issue_done_q && !valid_s1;
	assign sts.out_free   = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

`ifndef NO_ASSERTIONS
	// A scan only stalls when the result register is full and held.
	assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> (rsp_valid_q && rsp_stall))
		else $error("scan stalled with a free result register");

	// A new result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result register overwritten while stalled");

	// The hit count stays within the largest window.
	assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= gwns_pkg::CNT_W'(gwns_pkg::MAX_HITS))
		else $error("hit count beyond window size");

	// Read data in stage one exists only during a scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> cmd.scan)
		else $error("stage one valid outside a scan");
`endif

endmodule

`default_nettype wire

[rtl/core/grid_window_neighbour_scan_core.sv]
// Top level of the grid window neighbour scan core with its configuration port.
`default_nettype none

// Occupancy grid of up to 64 by 64 cells with one occupied bit and one 16-bit
// occupant id per cell. After reset the core runs a clearing pass over all 4096
// cells, one cell a cycle, during which it stalls requests; configuration
// writes are taken throughout. A request word writes one cell, counts the
// occupied cells in a square window of radius vicinity clipped to the grid,
// lists the occupants in it, or lists its free cells, scanning x outer and y
// inner. Cell writes and out-of-range requests skip the scan and go from the
// start state straight to the finish state. Window requests read the grid
// memory one cell a cycle through its single port whenever the result side
// does not stall. One request is processed at a time; a finished result word
// may wait in the output register while the next request is accepted.
// Register grid_extent lies at byte address 0.
module grid_window_neighbour_scan_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            req_valid,
	output logic                                 req_stall,
	input  wire gwns_pkg::req_word_t             req_word,
	output logic                                 rsp_valid,
	input  wire logic                            rsp_stall,
	output gwns_pkg::rsp_word_t                  rsp_word,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [gwns_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [gwns_pkg::PDATA_W-1:0]    pwdata,
	output logic [gwns_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);

	logic [gwns_pkg::EXT_W-1:0] grid_extent_q;
	gwns_pkg::cmd_t             cmd;
	gwns_pkg::sts_t             sts;
	logic                       reg_sel;

	// Register decode and write.
	assign reg_sel = (paddr[2] == gwns_pkg::REG_GRID_EXTENT);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_extent_q <= gwns_pkg::EXTENT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			grid_extent_q <= pwdata[gwns_pkg::EXT_W-1:0];
		end
	end

	assign prdata = reg_sel ? gwns_pkg::PDATA_W'(grid_extent_q) : '0;

	// Requests are stalled whenever the controller is not idle.
	assign req_stall = !cmd.ready;

	gwns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	gwns_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.grid_extent (grid_extent_q),
		.req_valid   (req_valid),
		.req_word    (req_word),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.rsp_word    (rsp_word),
		.rsp_stall   (rsp_stall)
	);

endmodule

`default_nettype wire
